@@ design/uart_buffered_tx_rx_rings_assert.svh @@
// Assertion macros shared by the ring buffer RTL.
`ifndef UART_BUFFERED_TX_RX_RINGS_ASSERT_SVH
`define UART_BUFFERED_TX_RX_RINGS_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define UBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger, outside reset.
`define UBR_ASSERT_NEXT(lbl, trig, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (post)) \
        else $error(msg);

`endif

@@ design/ubr_pkg.sv @@
// Types and constants shared by the UART ring buffer block.
package ubr_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEVEL_W      = 5;
    localparam int TX_DEPTH_DEF = 16;
    localparam int RX_DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_SERVICE = 2'd2
    } cmd_e_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [BYTE_W-1:0] data_byte;
        logic              rx_ready;
        logic              tx_ready;
    } ubr_in_t;

    typedef struct packed {
        logic               done_res;
        logic [BYTE_W-1:0]  read_byte;
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               tx_irq_enable;
        logic               rx_dropped;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } ubr_out_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_flags_t;

endpackage

@@ design/ubr_ring.sv @@
// Byte ring with free-running pointers modulo twice the depth and a registered read port.
`include "uart_buffered_tx_rx_rings_assert.svh"

module ubr_ring #(
    parameter int DEPTH = ubr_pkg::TX_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ubr_pkg::ring_ctrl_t          ctrl,
    input  logic [ubr_pkg::BYTE_W-1:0]   wr_data,
    output logic [ubr_pkg::BYTE_W-1:0]   rd_data,
    output ubr_pkg::ring_flags_t         flags,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    import ubr_pkg::*;

    localparam int PTR_W  = $clog2(2 * DEPTH);
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int LVL_W  = $clog2(DEPTH + 1);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_off, rd_off;
    logic [SLOT_W-1:0] wr_slot, rd_slot;
    logic [PTR_W:0]    level_wide;
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Fold each pointer onto its slot.
    assign wr_off  = (wr_ptr_reg >= PTR_W'(DEPTH)) ? wr_ptr_reg - PTR_W'(DEPTH) : wr_ptr_reg;
    assign rd_off  = (rd_ptr_reg >= PTR_W'(DEPTH)) ? rd_ptr_reg - PTR_W'(DEPTH) : rd_ptr_reg;
    assign wr_slot = wr_off[SLOT_W-1:0];
    assign rd_slot = rd_off[SLOT_W-1:0];

    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            level_wide = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        end
        else
        begin
            level_wide = {1'b0, wr_ptr_reg} + (PTR_W+1)'(2 * DEPTH) - {1'b0, rd_ptr_reg};
        end
    end

    assign level       = level_wide[LVL_W-1:0];
    assign flags.empty = (wr_ptr_reg == rd_ptr_reg);
    assign flags.full  = (level == LVL_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(2 * DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(2 * DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage and registered read; push and pop never hit the same item.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    assign rd_data = rd_data_reg;

    `UBR_ASSERT(a_no_push_full, !(ctrl.push && flags.full), "push into a full ring")
    `UBR_ASSERT(a_no_pop_empty, !(ctrl.pop && flags.empty), "pop from an empty ring")
    `UBR_ASSERT_NEXT(a_push_grows, ctrl.push && !ctrl.pop, level == $past(level) + LVL_W'(1), "level did not grow after push")
    `UBR_ASSERT_NEXT(a_pop_shrinks, ctrl.pop && !ctrl.push, level == $past(level) - LVL_W'(1), "level did not shrink after pop")
    `UBR_ASSERT(a_level_bound, level <= LVL_W'(DEPTH), "ring level beyond depth")

endmodule

@@ design/uart_buffered_tx_rx_rings.sv @@
// Top level: host-side transmit and receive rings for an interrupt-driven UART.
//
// The block takes one item per clock cycle: a host write (push a byte onto the
// transmit ring), a host read (pop a byte from the receive ring) or a service
// event (store a received byte, hand the oldest transmit byte out). An item is
// accepted whenever the result register is empty or is being drained in the same
// cycle, and its result appears in the cycle after acceptance, so the sustained
// rate is one item per cycle while results are drained. Each ring updates its
// pointers on acceptance, and the registered read port of the ring storage
// delivers the popped byte together with the result. Each result carries both
// fill levels after the item, the transmit interrupt enable, and whether a
// received byte was dropped on a full receive ring. Ring storage is not cleared
// at reset; only the pointers, the enable flag and the result flags are, so no
// clearing pass is needed. Levels are reported in five bits.
`include "uart_buffered_tx_rx_rings_assert.svh"

module uart_buffered_tx_rx_rings #(
    parameter int TX_DEPTH = ubr_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = ubr_pkg::RX_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ubr_pkg::ubr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ubr_pkg::ubr_out_t out_data
);
    import ubr_pkg::*;

    localparam int TX_LVL_W = $clog2(TX_DEPTH + 1);
    localparam int RX_LVL_W = $clog2(RX_DEPTH + 1);

    logic                accept;
    ring_ctrl_t          tx_ctrl, rx_ctrl;
    ring_flags_t         tx_flags, rx_flags;
    logic [TX_LVL_W-1:0] tx_level;
    logic [RX_LVL_W-1:0] rx_level;
    logic [BYTE_W-1:0]   tx_rd_data, rx_rd_data;

    logic out_valid_reg, out_valid_next;
    logic irq_en_reg,    irq_en_next;
    logic done_reg,      done_next;
    logic drop_reg,      drop_next;
    logic tx_pop_reg;
    logic rx_pop_reg;

    // Take a new item unless a finished result is stalled.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Decode the item into ring operations; gate on fill state.
    always_comb
    begin
        tx_ctrl     = '0;
        rx_ctrl     = '0;
        irq_en_next = irq_en_reg;
        done_next   = done_reg;
        drop_next   = drop_reg;
        if (accept)
        begin
            done_next = 1'b0;
            drop_next = 1'b0;
            unique case (cmd_e_t'(in_data.command))
                CMD_WRITE:
                begin
                    tx_ctrl.push = !tx_flags.full;
                    done_next    = !tx_flags.full;
                    // Ring is never empty after a write: arm the interrupt.
                    if (tx_ctrl.push || !tx_flags.empty)
                    begin
                        irq_en_next = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    rx_ctrl.pop = !rx_flags.empty;
                    done_next   = !rx_flags.empty;
                end
                CMD_SERVICE:
                begin
                    if (in_data.rx_ready)
                    begin
                        rx_ctrl.push = !rx_flags.full;
                        drop_next    = rx_flags.full;
                    end
                    if (in_data.tx_ready)
                    begin
                        tx_ctrl.pop = !tx_flags.empty;
                        // Nothing left to send: disarm the interrupt.
                        if (tx_flags.empty)
                        begin
                            irq_en_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // Unused code: no change, flags cleared above.
                end
            endcase
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            irq_en_reg    <= 1'b0;
            done_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            tx_pop_reg    <= 1'b0;
            rx_pop_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            irq_en_reg    <= irq_en_next;
            done_reg      <= done_next;
            drop_reg      <= drop_next;
            if (accept)
            begin
                tx_pop_reg <= tx_ctrl.pop;
                rx_pop_reg <= rx_ctrl.pop;
            end
        end
    end

    ubr_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tx_ctrl),
        .wr_data (in_data.data_byte),
        .rd_data (tx_rd_data),
        .flags   (tx_flags),
        .level   (tx_level)
    );

    ubr_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rx_ctrl),
        .wr_data (in_data.data_byte),
        .rd_data (rx_rd_data),
        .flags   (rx_flags),
        .level   (rx_level)
    );

    // Pointers and the enable flag change only on acceptance, so while a result
    // waits they still describe the state just after its item.
    assign out_valid              = out_valid_reg;
    assign out_data.done_res      = done_reg;
    assign out_data.read_byte     = rx_pop_reg ? rx_rd_data : '0;
    assign out_data.tx_valid      = tx_pop_reg;
    assign out_data.tx_byte       = tx_pop_reg ? tx_rd_data : '0;
    assign out_data.tx_irq_enable = irq_en_reg;
    assign out_data.rx_dropped    = drop_reg;
    assign out_data.rx_level      = LEVEL_W'(rx_level);
    assign out_data.tx_level      = LEVEL_W'(tx_level);

endmodule

@@ verif/uart_buffered_tx_rx_rings_tb.sv @@
// Self-checking testbench for the UART transmit and receive ring block.
module uart_buffered_tx_rx_rings_tb;
    import ubr_pkg::*;

    // Depths match the defaults that the block is built with here.
    localparam int TXD = TX_DEPTH_DEF;
    localparam int RXD = RX_DEPTH_DEF;

    // The one command code that the package leaves without a meaning.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1570;
    localparam int MAX_GAP      = 10;
    localparam int SETTLE_TICKS = 5;

    // Traffic mixes for the random part: lean towards filling the rings,
    // towards draining them, or keep pushes and pops even.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_mix_t;

    // One row of the directed table. A row is sent count times, with the data
    // byte stepped by one on each repeat. Where typed is set, result holds
    // the status read straight off the behaviour; elsewhere the ring
    // predictor supplies it.
    typedef struct {
        ubr_in_t  item;
        int       count;
        bit       typed;
        ubr_out_t result;
    } stim_row_t;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    ubr_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    ubr_out_t out_data;

    // Ring shadow state kept by the predictor.
    logic [BYTE_W-1:0] tx_ring [TXD];
    logic [BYTE_W-1:0] rx_ring [RXD];
    int   tx_wr  = 0;
    int   tx_rd  = 0;
    int   rx_wr  = 0;
    int   rx_rd  = 0;
    logic irq_en = 1'b0;

    // Status items still owed by the block, oldest first.
    ubr_out_t  pending_status_q [$];
    stim_row_t stim_rows [$];

    int       fail_count  = 0;
    bit       send_quiet  = 1'b0;
    bit       drain_quiet = 1'b0;
    ubr_out_t owed_status;

    uart_buffered_tx_rx_rings u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Fill level of a ring whose pointers run modulo twice its depth.
    function automatic int ring_fill(input int wr, input int rd, input int depth);
        return (wr >= rd) ? wr - rd : wr + 2 * depth - rd;
    endfunction

    function automatic int ptr_advance(input int p, input int depth);
        return (p + 1 >= 2 * depth) ? 0 : p + 1;
    endfunction

    // Apply one item to the shadow rings and return the status it should raise.
    function automatic ubr_out_t uart_rings_step(input ubr_in_t item);
        ubr_out_t res;
        res = '0;
        case (item.command)
            CMD_WRITE:
            begin
                if (ring_fill(tx_wr, tx_rd, TXD) < TXD)
                begin
                    tx_ring[tx_wr % TXD] = item.data_byte;
                    tx_wr = ptr_advance(tx_wr, TXD);
                    res.done_res = 1'b1;
                end
                // The enable follows the ring, even when the byte was refused.
                if (tx_wr != tx_rd)
                    irq_en = 1'b1;
            end
            CMD_READ:
            begin
                if (rx_wr != rx_rd)
                begin
                    res.read_byte = rx_ring[rx_rd % RXD];
                    rx_rd = ptr_advance(rx_rd, RXD);
                    res.done_res = 1'b1;
                end
            end
            CMD_SERVICE:
            begin
                if (item.rx_ready)
                begin
                    if (ring_fill(rx_wr, rx_rd, RXD) < RXD)
                    begin
                        rx_ring[rx_wr % RXD] = item.data_byte;
                        rx_wr = ptr_advance(rx_wr, RXD);
                    end
                    else
                        res.rx_dropped = 1'b1;
                end
                if (item.tx_ready)
                begin
                    if (tx_wr != tx_rd)
                    begin
                        res.tx_byte  = tx_ring[tx_rd % TXD];
                        res.tx_valid = 1'b1;
                        tx_rd = ptr_advance(tx_rd, TXD);
                    end
                    else
                        irq_en = 1'b0;
                end
            end
            default: ;
        endcase
        res.tx_irq_enable = irq_en;
        res.rx_level      = LEVEL_W'(ring_fill(rx_wr, rx_rd, RXD));
        res.tx_level      = LEVEL_W'(ring_fill(tx_wr, tx_rd, TXD));
        return res;
    endfunction

    function automatic ubr_in_t mk_in(input logic [1:0] cmd, input logic [7:0] data,
                                      input logic rx, input logic tx);
        ubr_in_t item;
        item.command   = cmd;
        item.data_byte = data;
        item.rx_ready  = rx;
        item.tx_ready  = tx;
        return item;
    endfunction

    function automatic ubr_out_t mk_out(input logic done, input logic [7:0] rbyte,
                                        input logic txv, input logic [7:0] txb,
                                        input logic irq, input logic drop,
                                        input logic [4:0] rxl, input logic [4:0] txl);
        ubr_out_t res;
        res.done_res      = done;
        res.read_byte     = rbyte;
        res.tx_valid      = txv;
        res.tx_byte       = txb;
        res.tx_irq_enable = irq;
        res.rx_dropped    = drop;
        res.rx_level      = rxl;
        res.tx_level      = txl;
        return res;
    endfunction

    function automatic void add_row(input ubr_in_t item, input int count,
                                    input bit typed, input ubr_out_t result);
        stim_row_t row;
        row.item   = item;
        row.count  = count;
        row.typed  = typed;
        row.result = result;
        stim_rows.push_back(row);
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one item after an idle gap, hold it until the block takes it, then
    // log the status that it owes. Valid is only touched once per clock edge:
    // lowered for a gap, or raised again with the new item.
    task automatic send_item(input ubr_in_t item, input bit typed, input ubr_out_t given);
        int       gap;
        ubr_out_t predicted;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = uart_rings_step(item);
        pending_status_q.push_back(typed ? given : predicted);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Check every status item that the block hands over against the oldest
    // one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status_q.size() == 0)
            begin
                $display("%0t: status item with none owed, expected none, actual %h",
                         $time, out_data);
                fail_count++;
            end
            else
            begin
                owed_status = pending_status_q.pop_front();
                check_field("done_res",      8'(owed_status.done_res),      8'(out_data.done_res));
                check_field("read_byte",     owed_status.read_byte,         out_data.read_byte);
                check_field("tx_valid",      8'(owed_status.tx_valid),      8'(out_data.tx_valid));
                check_field("tx_byte",       owed_status.tx_byte,           out_data.tx_byte);
                check_field("tx_irq_enable", 8'(owed_status.tx_irq_enable),
                            8'(out_data.tx_irq_enable));
                check_field("rx_dropped",    8'(owed_status.rx_dropped),    8'(out_data.rx_dropped));
                check_field("rx_level",      8'(owed_status.rx_level),      8'(out_data.rx_level));
                check_field("tx_level",      8'(owed_status.tx_level),      8'(out_data.tx_level));
            end
        end
    end

    // Result side: stall for a drawn number of cycles before each item, and
    // now and then switch to a stretch with no stalls at all.
    initial
    begin : drain_side
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                drain_quiet = !drain_quiet;
            gap = draw_gap(drain_quiet);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int           r;
        int           k;
        int           n;
        int           burst_left;
        int           w_wr;
        int           w_rd;
        int           p_rx;
        int           p_tx;
        int           pick;
        traffic_mix_t mix;
        ubr_in_t      item;
        logic [1:0]   cmd;

        burst_left = 0;
        w_wr = 30;
        w_rd = 30;
        p_rx = 50;
        p_tx = 50;

        // Empty rings straight after reset: a read finds nothing, a transmit
        // request on an empty ring leaves the enable low, and neither a bare
        // service event nor the unused code changes anything.
        add_row(mk_in(CMD_READ,    8'h00, 1'b0, 1'b0), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0, 5'd0));
        add_row(mk_in(CMD_SERVICE, 8'h00, 1'b0, 1'b1), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0, 5'd0));
        add_row(mk_in(CMD_SERVICE, 8'hFF, 1'b0, 1'b0), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0, 5'd0));
        add_row(mk_in(CMD_UNUSED,  8'hFF, 1'b1, 1'b1), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0, 5'd0));
        // Push the extreme bytes, then hand them out, one alongside a receive.
        add_row(mk_in(CMD_WRITE,   8'hFF, 1'b0, 1'b0), 1, 1'b1,
                mk_out(1'b1, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 5'd0, 5'd1));
        add_row(mk_in(CMD_WRITE,   8'h00, 1'b1, 1'b1), 1, 1'b1,
                mk_out(1'b1, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 5'd0, 5'd2));
        add_row(mk_in(CMD_SERVICE, 8'h00, 1'b0, 1'b1), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b0, 5'd0, 5'd1));
        add_row(mk_in(CMD_SERVICE, 8'h00, 1'b1, 1'b1), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 5'd1, 5'd0));
        // Transmit ring now empty: the next transmit request drops the enable.
        add_row(mk_in(CMD_SERVICE, 8'hFF, 1'b0, 1'b1), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd1, 5'd0));
        add_row(mk_in(CMD_READ,    8'hFF, 1'b1, 1'b1), 1, 1'b1,
                mk_out(1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0, 5'd0));
        // Fill the transmit ring, then write once more into the full ring.
        add_row(mk_in(CMD_WRITE,   8'h10, 1'b0, 1'b0), TXD, 1'b0, '0);
        add_row(mk_in(CMD_WRITE,   8'h5A, 1'b0, 1'b0), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 5'd0, 5'd16));
        // Fill the receive ring, then receive once more so the byte is dropped.
        add_row(mk_in(CMD_SERVICE, 8'h80, 1'b1, 1'b0), RXD, 1'b0, '0);
        add_row(mk_in(CMD_SERVICE, 8'h7F, 1'b1, 1'b0), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 5'd16, 5'd16));
        add_row(mk_in(CMD_UNUSED,  8'h00, 1'b0, 1'b0), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 5'd16, 5'd16));
        // Drop on receive and hand out a byte in the same service event.
        add_row(mk_in(CMD_SERVICE, 8'hFF, 1'b1, 1'b1), 1, 1'b0, '0);
        // Drain both rings past empty, then read once more from nothing.
        add_row(mk_in(CMD_READ,    8'h00, 1'b0, 1'b0), RXD + 1, 1'b0, '0);
        add_row(mk_in(CMD_SERVICE, 8'h00, 1'b0, 1'b1), TXD, 1'b0, '0);
        add_row(mk_in(CMD_READ,    8'h00, 1'b0, 1'b0), 1, 1'b1,
                mk_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0, 5'd0));

        // Hold reset once, at the start, then release it.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < stim_rows.size(); r++)
        begin
            for (k = 0; k < stim_rows[r].count; k++)
            begin
                item = stim_rows[r].item;
                item.data_byte = item.data_byte + 8'(k);
                send_item(item, stim_rows[r].typed, stim_rows[r].result);
            end
        end

        // Random traffic in bursts, each with its own mix, so that both rings
        // swing between empty and full and the pointers wrap many times.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(20, 80);
                mix        = traffic_mix_t'($urandom_range(0, 2));
                send_quiet = ($urandom_range(0, 3) == 0);
                case (mix)
                    MIX_FILL:
                    begin
                        w_wr = 45;
                        w_rd = 10;
                        p_rx = 85;
                        p_tx = 15;
                    end
                    MIX_DRAIN:
                    begin
                        w_wr = 10;
                        w_rd = 45;
                        p_rx = 15;
                        p_tx = 85;
                    end
                    default:
                    begin
                        w_wr = 30;
                        w_rd = 30;
                        p_rx = 50;
                        p_tx = 50;
                    end
                endcase
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < 3 + w_wr)
                cmd = CMD_WRITE;
            else if (pick < 3 + w_wr + w_rd)
                cmd = CMD_READ;
            else
                cmd = CMD_SERVICE;

            // Ready bits are drawn for every command, so they also ride along
            // as noise on writes and reads.
            item = mk_in(cmd, 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 99) < p_rx), ($urandom_range(0, 99) < p_tx));
            send_item(item, 1'b0, '0);
        end

        // Drop valid on the edge that took the last item, wait for every owed
        // status, then go on watching for any stray item before the verdict.
        in_valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (fail_count == 0 && pending_status_q.size() == 0)
            $display("uart_buffered_tx_rx_rings verification clean");
        else
            $display("uart_buffered_tx_rx_rings verification failed");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #1000000;
        $display("uart_buffered_tx_rx_rings verification failed");
        $finish;
    end

endmodule
